FILE: rtl/core/ktbp_pkg.sv
// ----------------------------------------------------------------------------
// Keyed token-bucket policer package
// Shared types, codes and helper functions of the policer.
// ----------------------------------------------------------------------------
package ktbp_pkg;

   localparam int TableEntriesDefault = 64;
   localparam logic [25:0] Cost = 26'd60;

   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_SWEEP   = 2'd2;

   localparam logic [1:0] DENY_NONE    = 2'd0;
   localparam logic [1:0] DENY_GLOBAL  = 2'd1;
   localparam logic [1:0] DENY_ADDRESS = 2'd2;
   localparam logic [1:0] DENY_CLIENT  = 2'd3;

   localparam logic [2:0] REG_ENABLED    = 3'd0;
   localparam logic [2:0] REG_GLOBAL     = 3'd1;
   localparam logic [2:0] REG_ADDRESS    = 3'd2;
   localparam logic [2:0] REG_CLIENT     = 3'd3;
   localparam logic [2:0] REG_BURST      = 3'd4;
   localparam logic [2:0] REG_ADDR_LIMIT = 3'd5;
   localparam logic [2:0] REG_CLI_LIMIT  = 3'd6;
   localparam logic [2:0] REG_STALE      = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address_key;
      logic        address_present;
      logic [63:0] client_key;
      logic        client_present;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic [1:0]  deny_reason;
      logic [6:0]  address_count;
      logic [6:0]  client_count;
      logic [31:0] request_total;
      logic [31:0] denied_total;
      logic [6:0]  address_swept;
      logic [6:0]  client_swept;
   } rsp_type;

   // One bucket as held in a table, stored by LRU position.
   typedef struct packed {
      logic [63:0] key;
      logic [25:0] tokens;
      logic [31:0] last;
   } bucket_type;

   typedef struct packed {
      logic [25:0] tokens;
      logic [31:0] last;
      logic [15:0] rate;
      logic [25:0] cap;
      logic [31:0] now;
      logic [15:0] stale;
   } refill_in_type;

   typedef struct packed {
      logic [25:0] tokens_left;
      logic        ok;
      logic        full;
      logic        idle_long;
   } refill_out_type;

   function automatic logic [25:0] cap_of(input logic [15:0] rate, input logic [4:0] burst);
      logic [4:0]  b;
      logic [20:0] rb;
      logic [26:0] c;
      b = (burst == 5'd0) ? 5'd1 : ((burst > 5'd16) ? 5'd16 : burst);
      rb = 21'(rate) * 21'(b);
      // Times sixty as a shift and subtract.
      c = (27'(rb) << 6) - (27'(rb) << 2);
      return c[25:0];
   endfunction

endpackage

FILE: rtl/core/ktbp_if.sv
// ----------------------------------------------------------------------------
// Policer channel interfaces
// Valid/ready channels that carry a request item and a result item.
// ----------------------------------------------------------------------------
interface ktbp_req_if;
   logic             valid;
   logic             ready;
   ktbp_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ktbp_rsp_if;
   logic             valid;
   logic             ready;
   ktbp_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ktbp_refill.sv
// ----------------------------------------------------------------------------
// Policer refill unit
// Two-stage shared unit: refills a bucket, takes one token and grades it.
// ----------------------------------------------------------------------------
module ktbp_refill (
   input  logic                     clock,
   input  ktbp_pkg::refill_in_type  op,
   output ktbp_pkg::refill_out_type res
);
   logic [47:0] prod_ff, prod_in;
   logic [31:0] el_ff, el_in;
   logic [25:0] tok_ff, cap_ff;
   logic [15:0] stale_ff;
   ktbp_pkg::refill_out_type res_ff, res_in;
   logic [48:0] sum;
   logic [25:0] t;

   always_comb begin
      el_in = (op.now >= op.last) ? (op.now - op.last) : 32'd0;
      prod_in = 48'(el_in) * 48'(op.rate);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      el_ff    <= el_in;
      tok_ff   <= op.tokens;
      cap_ff   <= op.cap;
      stale_ff <= op.stale;
   end

   always_comb begin
      sum = 49'(tok_ff) + 49'(prod_ff);
      t = (sum > 49'(cap_ff)) ? cap_ff : sum[25:0];
      res_in.ok = (t >= ktbp_pkg::Cost);
      res_in.tokens_left = res_in.ok ? (t - ktbp_pkg::Cost) : t;
      res_in.full = ((31'(t) * 31'd20) >= (31'(cap_ff) * 31'd19));
      res_in.idle_long = (el_ff > 32'(stale_ff));
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;
endmodule

FILE: rtl/core/ktbp_lru_mem.sv
// ----------------------------------------------------------------------------
// Policer bucket memory
// Buckets of one table, held in LRU order: position 0 is most recently used.
// ----------------------------------------------------------------------------
module ktbp_lru_mem #(
   parameter int TableEntries = ktbp_pkg::TableEntriesDefault
) (
   input  logic                             clock,
   input  logic [$clog2(TableEntries)-1:0]  rd_addr,
   output ktbp_pkg::bucket_type             rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(TableEntries)-1:0]  wr_addr,
   input  ktbp_pkg::bucket_type             wr_data
);
   ktbp_pkg::bucket_type mem_ff [TableEntries];
   ktbp_pkg::bucket_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

FILE: rtl/core/keyed_token_bucket_policer_unit.sv
// ----------------------------------------------------------------------------
// Keyed token-bucket policer
// Global, per-address and per-client buckets; LRU tables searched serially.
// ----------------------------------------------------------------------------
// A tick's result is offered in the cycle after acceptance; a request searches and
// then shifts the entries of each table it checks, one entry at a time.
// Throughput: one transaction at a time; the serial table walk over the
// bucket memory, with one read and one write port, and the two-stage refill unit limit it.
// A sweep reads, refills and grades one bucket at a time. Synchronous reset empties both
// tables at once through their fill counts; no clearing pass is needed.
module keyed_token_bucket_policer_unit #(
   parameter int TableEntries = ktbp_pkg::TableEntriesDefault
) (
   input  logic               clock,
   input  logic               reset,
   ktbp_req_if.sink           req_ch,
   ktbp_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);
   localparam int AW = $clog2(TableEntries);
   localparam int CW = $clog2(TableEntries + 1);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_TBL       = 13'b0000000000010,
      S_LOOK_RD   = 13'b0000000000100,
      S_LOOK_CMP  = 13'b0000000001000,
      S_EVICT     = 13'b0000000010000,
      S_SHIFT_RD  = 13'b0000000100000,
      S_SHIFT_WR  = 13'b0000001000000,
      S_MATH      = 13'b0000010000000,
      S_MATH_W    = 13'b0000100000000,
      S_MATH_RES  = 13'b0001000000000,
      S_SWEEP_RD  = 13'b0010000000000,
      S_SWEEP_LAT = 13'b0100000000000,
      S_RESP      = 13'b1000000000000
   } state_type;

   typedef enum logic [1:0] {PH_GLOB, PH_TBL, PH_SWEEP} phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   ktbp_pkg::req_type item_ff, item_in;
   ktbp_pkg::bucket_type rec_ff, rec_in;
   logic [31:0] now_ff, now_in, glast_ff, glast_in;
   logic [25:0] gtok_ff, gtok_in;
   logic [31:0] reqcnt_ff, reqcnt_in, dencnt_ff, dencnt_in;
   logic [CW-1:0] acnt_ff, acnt_in, ccnt_ff, ccnt_in;
   logic [CW-1:0] aswp_ff, aswp_in, cswp_ff, cswp_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [1:0] reason_ff, reason_in, tbl_ff, tbl_in;
   logic en_ff, en_in;
   logic [15:0] grate_ff, grate_in, arate_ff, arate_in, crate_ff, crate_in;
   logic [15:0] stale_ff, stale_in;
   logic [4:0] burst_ff, burst_in;
   logic [6:0] alim_ff, alim_in, clim_ff, clim_in;

   ktbp_pkg::refill_in_type mu_op;
   ktbp_pkg::refill_out_type mu_res;
   ktbp_pkg::bucket_type a_rd, c_rd, t_rd, wr_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic a_wr, c_wr, wr_en;

   logic sel_cli;
   logic [15:0] t_rate;
   logic [63:0] t_key;
   logic t_present;
   logic [6:0] t_lim_raw;
   logic [CW-1:0] t_cnt, t_lim, evict_cnt;
   logic [25:0] t_cap;

   ktbp_refill u_refill (.clock(clock), .op(mu_op), .res(mu_res));

   ktbp_lru_mem #(.TableEntries(TableEntries)) u_addr_mem (
      .clock(clock), .rd_addr(rd_addr), .rd_data(a_rd),
      .wr_en(a_wr), .wr_addr(wr_addr), .wr_data(wr_data));

   ktbp_lru_mem #(.TableEntries(TableEntries)) u_cli_mem (
      .clock(clock), .rd_addr(rd_addr), .rd_data(c_rd),
      .wr_en(c_wr), .wr_addr(wr_addr), .wr_data(wr_data));

   // Selection of the table now being worked on.
   always_comb begin
      sel_cli   = tbl_ff[0];
      t_rate    = sel_cli ? crate_ff : arate_ff;
      t_key     = sel_cli ? item_ff.client_key : item_ff.address_key;
      t_present = sel_cli ? item_ff.client_present : item_ff.address_present;
      t_lim_raw = sel_cli ? clim_ff : alim_ff;
      t_cnt     = sel_cli ? ccnt_ff : acnt_ff;
      t_rd      = sel_cli ? c_rd : a_rd;
      t_cap     = ktbp_pkg::cap_of(t_rate, burst_ff);
      if (32'(t_lim_raw) > 32'(TableEntries)) begin
         t_lim = CW'(TableEntries);
      end else if (t_lim_raw == 7'd0) begin
         t_lim = CW'(1);
      end else begin
         t_lim = CW'(t_lim_raw);
      end
      evict_cnt = ((t_cnt >= t_lim) && (t_cnt != '0)) ? (t_cnt - CW'(1)) : t_cnt;
   end

   always_comb begin
      mu_op.now   = now_ff;
      mu_op.stale = stale_ff;
      if (phase_ff == PH_GLOB) begin
         mu_op.tokens = gtok_ff;
         mu_op.last   = glast_ff;
         mu_op.rate   = grate_ff;
         mu_op.cap    = ktbp_pkg::cap_of(grate_ff, burst_ff);
      end else begin
         mu_op.tokens = rec_ff.tokens;
         mu_op.last   = rec_ff.last;
         mu_op.rate   = t_rate;
         mu_op.cap    = t_cap;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_LOOK_RD:  rd_addr = ptr_ff[AW-1:0];
         S_SHIFT_RD: rd_addr = AW'(ptr_ff - CW'(1));
         default:    rd_addr = AW'(t_cnt - CW'(1));
      endcase
      wr_en = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = t_rd;
      if (state_ff == S_SHIFT_WR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_MATH_RES && phase_ff == PH_TBL) begin
         wr_en = 1'b1;
         wr_addr = '0;
         wr_data.key = rec_ff.key;
         wr_data.tokens = mu_res.tokens_left;
         wr_data.last = now_ff;
      end
      a_wr = wr_en && !sel_cli;
      c_wr = wr_en && sel_cli;
   end

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; item_in = item_ff; rec_in = rec_ff;
      now_in = now_ff; glast_in = glast_ff; gtok_in = gtok_ff;
      reqcnt_in = reqcnt_ff; dencnt_in = dencnt_ff;
      acnt_in = acnt_ff; ccnt_in = ccnt_ff; aswp_in = aswp_ff; cswp_in = cswp_ff;
      ptr_in = ptr_ff; reason_in = reason_ff; tbl_in = tbl_ff;
      en_in = en_ff; grate_in = grate_ff; arate_in = arate_ff; crate_in = crate_ff;
      stale_in = stale_ff; burst_in = burst_ff; alim_in = alim_ff; clim_in = clim_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               item_in = req_ch.payload;
               reason_in = ktbp_pkg::DENY_NONE;
               aswp_in = '0;
               cswp_in = '0;
               tbl_in = 2'd0;
               state_in = S_RESP;
               unique case (req_ch.payload.kind)
                  ktbp_pkg::KIND_REQUEST: begin
                     if (en_ff) begin
                        if (reqcnt_ff != 32'hFFFF_FFFF) reqcnt_in = reqcnt_ff + 32'd1;
                        if (grate_ff != 16'd0) begin
                           phase_in = PH_GLOB;
                           state_in = S_MATH;
                        end else begin
                           state_in = S_TBL;
                        end
                     end
                  end
                  ktbp_pkg::KIND_TICK: begin
                     if (now_ff != 32'hFFFF_FFFF) now_in = now_ff + 32'd1;
                  end
                  ktbp_pkg::KIND_SWEEP: begin
                     if (en_ff) begin
                        phase_in = PH_SWEEP;
                        state_in = S_SWEEP_RD;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_TBL: begin
            phase_in = PH_TBL;
            ptr_in = '0;
            if (tbl_ff == 2'd2) begin
               state_in = S_RESP;
            end else if (t_rate != 16'd0 && t_present) begin
               state_in = S_LOOK_RD;
            end else begin
               tbl_in = tbl_ff + 2'd1;
            end
         end
         S_LOOK_RD: begin
            state_in = (ptr_ff == t_cnt) ? S_EVICT : S_LOOK_CMP;
         end
         S_LOOK_CMP: begin
            if (t_rd.key == t_key) begin
               rec_in = t_rd;
               state_in = S_SHIFT_RD;
            end else begin
               ptr_in = ptr_ff + CW'(1);
               state_in = S_LOOK_RD;
            end
         end
         S_EVICT: begin
            // The least recently used bucket simply falls off the end.
            if (sel_cli) ccnt_in = evict_cnt + CW'(1);
            else acnt_in = evict_cnt + CW'(1);
            ptr_in = evict_cnt;
            rec_in.key = t_key;
            rec_in.tokens = t_cap;
            rec_in.last = now_ff;
            state_in = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            state_in = (ptr_ff == '0) ? S_MATH : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            ptr_in = ptr_ff - CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_MATH:   state_in = S_MATH_W;
         S_MATH_W: state_in = S_MATH_RES;
         S_MATH_RES: begin
            unique case (phase_ff)
               PH_GLOB: begin
                  gtok_in = mu_res.tokens_left;
                  glast_in = now_ff;
                  if (mu_res.ok) begin
                     state_in = S_TBL;
                  end else begin
                     reason_in = ktbp_pkg::DENY_GLOBAL;
                     if (dencnt_ff != 32'hFFFF_FFFF) dencnt_in = dencnt_ff + 32'd1;
                     state_in = S_RESP;
                  end
               end
               PH_TBL: begin
                  if (mu_res.ok) begin
                     tbl_in = tbl_ff + 2'd1;
                     state_in = S_TBL;
                  end else begin
                     reason_in = sel_cli ? ktbp_pkg::DENY_CLIENT : ktbp_pkg::DENY_ADDRESS;
                     if (dencnt_ff != 32'hFFFF_FFFF) dencnt_in = dencnt_ff + 32'd1;
                     state_in = S_RESP;
                  end
               end
               default: begin
                  if (mu_res.full && mu_res.idle_long) begin
                     if (sel_cli) begin
                        ccnt_in = ccnt_ff - CW'(1);
                        cswp_in = cswp_ff + CW'(1);
                     end else begin
                        acnt_in = acnt_ff - CW'(1);
                        aswp_in = aswp_ff + CW'(1);
                     end
                     state_in = S_SWEEP_RD;
                  end else begin
                     tbl_in = 2'd1;
                     state_in = sel_cli ? S_RESP : S_SWEEP_RD;
                  end
               end
            endcase
         end
         S_SWEEP_RD: begin
            if (t_cnt == '0) begin
               tbl_in = 2'd1;
               state_in = sel_cli ? S_RESP : S_SWEEP_RD;
            end else begin
               state_in = S_SWEEP_LAT;
            end
         end
         S_SWEEP_LAT: begin
            rec_in = t_rd;
            state_in = S_MATH;
         end
         S_RESP: begin
            if (rsp_ch.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            ktbp_pkg::REG_ENABLED: en_in = csr_wr_data[0];
            ktbp_pkg::REG_GLOBAL: begin
               grate_in = csr_wr_data;
               gtok_in = ktbp_pkg::cap_of(csr_wr_data, burst_ff);
               glast_in = now_ff;
            end
            ktbp_pkg::REG_ADDRESS: arate_in = csr_wr_data;
            ktbp_pkg::REG_CLIENT:  crate_in = csr_wr_data;
            ktbp_pkg::REG_BURST: begin
               burst_in = csr_wr_data[4:0];
               gtok_in = ktbp_pkg::cap_of(grate_ff, csr_wr_data[4:0]);
               glast_in = now_ff;
            end
            ktbp_pkg::REG_ADDR_LIMIT: alim_in = csr_wr_data[6:0];
            ktbp_pkg::REG_CLI_LIMIT:  clim_in = csr_wr_data[6:0];
            default: stale_in = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_GLOB;
         now_ff <= '0;
         glast_ff <= '0;
         gtok_ff <= '0;
         reqcnt_ff <= '0;
         dencnt_ff <= '0;
         acnt_ff <= '0;
         ccnt_ff <= '0;
         aswp_ff <= '0;
         cswp_ff <= '0;
         ptr_ff <= '0;
         reason_ff <= ktbp_pkg::DENY_NONE;
         tbl_ff <= '0;
         en_ff <= 1'b0;
         grate_ff <= '0;
         arate_ff <= '0;
         crate_ff <= '0;
         burst_ff <= 5'd1;
         alim_ff <= 7'd64;
         clim_ff <= 7'd64;
         stale_ff <= 16'd300;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         now_ff <= now_in;
         glast_ff <= glast_in;
         gtok_ff <= gtok_in;
         reqcnt_ff <= reqcnt_in;
         dencnt_ff <= dencnt_in;
         acnt_ff <= acnt_in;
         ccnt_ff <= ccnt_in;
         aswp_ff <= aswp_in;
         cswp_ff <= cswp_in;
         ptr_ff <= ptr_in;
         reason_ff <= reason_in;
         tbl_ff <= tbl_in;
         en_ff <= en_in;
         grate_ff <= grate_in;
         arate_ff <= arate_in;
         crate_ff <= crate_in;
         burst_ff <= burst_in;
         alim_ff <= alim_in;
         clim_ff <= clim_in;
         stale_ff <= stale_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rec_ff <= rec_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RESP);

   always_comb begin
      rsp_ch.payload.allowed       = (reason_ff == ktbp_pkg::DENY_NONE);
      rsp_ch.payload.deny_reason   = reason_ff;
      rsp_ch.payload.address_count = 7'(acnt_ff);
      rsp_ch.payload.client_count  = 7'(ccnt_ff);
      rsp_ch.payload.request_total = reqcnt_ff;
      rsp_ch.payload.denied_total  = dencnt_ff;
      rsp_ch.payload.address_swept = 7'(aswp_ff);
      rsp_ch.payload.client_swept  = 7'(cswp_ff);
   end

   // The block never takes a transaction while a result is still on offer.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while a result is pending");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      32'(acnt_ff) <= 32'(TableEntries))
      else $error("address table overfilled");

   a_cli_bound: assert property (@(posedge clock) disable iff (reset)
      32'(ccnt_ff) <= 32'(TableEntries))
      else $error("client table overfilled");

   a_deny_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && reason_ff != ktbp_pkg::DENY_NONE)
      |-> (dencnt_ff != 32'd0))
      else $error("denial reported without being counted");
endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Keyed token-bucket policer testbench
// Directed and random transactions against a behavioural predictor of the
// global bucket, the two LRU key tables, sweeping and the saturating counters,
// with random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int Entries = ktbp_pkg::TableEntriesDefault;
   // Kind value that the block ignores.
   localparam logic [1:0] KindUnused = 2'd3;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [15:0] csr_wr_data;

   ktbp_req_if req_ch ();
   ktbp_rsp_if rsp_ch ();

   keyed_token_bucket_policer_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // Predicted policer state; each table is held in LRU order, index 0 newest.
   typedef struct {
      logic [63:0] key;
      logic [31:0] tokens;
      logic [31:0] last;
   } bucket_rec_type;

   logic [15:0] p_enabled, p_grate, p_arate, p_crate, p_burst, p_alim, p_clim, p_stale;
   logic [31:0] p_now, p_gtok, p_glast, p_reqs, p_denied;
   bucket_rec_type addr_lru[$];
   bucket_rec_type cli_lru[$];

   ktbp_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int checked = 0;
   int sent = 0;
   int cycle = 0;
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_off = 0;
   int sweeps_seen = 0;
   int denials_seen = 0;

   typedef struct {
      ktbp_pkg::req_type item;
      bit has_rsp;
      ktbp_pkg::rsp_type rsp;
   } stim_row_type;

   function automatic logic [31:0] capacity(input logic [15:0] rate);
      logic [31:0] b;
      b = (p_burst[4:0] == 0) ? 1 : ((p_burst[4:0] > 16) ? 16 : p_burst[4:0]);
      return rate * b * 60;
   endfunction

   function automatic int limit_of(input logic [15:0] lim);
      int l;
      l = int'(lim[6:0]);
      if (l > Entries) l = Entries;
      if (l < 1) l = 1;
      return l;
   endfunction

   function automatic logic [31:0] topped_up(input logic [31:0] tok, input logic [31:0] last,
                                             input logic [15:0] rate);
      logic [63:0] t;
      logic [31:0] c;
      c = capacity(rate);
      t = 64'(tok) + ((p_now >= last) ? 64'(p_now - last) : 64'd0) * 64'(rate);
      return (t > 64'(c)) ? c : t[31:0];
   endfunction

   function automatic bit spend_token(inout logic [31:0] tok, inout logic [31:0] last,
                                      input logic [15:0] rate);
      logic [31:0] t;
      t = topped_up(tok, last, rate);
      last = p_now;
      if (t >= 60) begin
         tok = t - 60;
         return 1;
      end
      tok = t;
      return 0;
   endfunction

   function automatic bit police_key(ref bucket_rec_type lru[$], input logic [63:0] key,
                                     input logic [15:0] rate, input logic [15:0] lim);
      bucket_rec_type b;
      int pos;
      bit ok;
      pos = -1;
      foreach (lru[i]) if (pos < 0 && lru[i].key == key) pos = i;
      if (pos >= 0) begin
         b = lru[pos];
         lru.delete(pos);
      end else begin
         if (lru.size() >= limit_of(lim) && lru.size() > 0) lru.delete(lru.size() - 1);
         b.key = key;
         b.tokens = capacity(rate);
         b.last = p_now;
      end
      ok = spend_token(b.tokens, b.last, rate);
      lru.insert(0, b);
      return ok;
   endfunction

   function automatic int sweep_stale(ref bucket_rec_type lru[$], input logic [15:0] rate);
      int n;
      logic [31:0] t, c, idle;
      n = 0;
      c = capacity(rate);
      while (lru.size() > 0) begin
         t = topped_up(lru[$].tokens, lru[$].last, rate);
         idle = (p_now >= lru[$].last) ? p_now - lru[$].last : 0;
         if (!(64'(t) * 20 >= 64'(c) * 19 && idle > 32'(p_stale))) break;
         lru.delete(lru.size() - 1);
         n++;
      end
      return n;
   endfunction

   function automatic ktbp_pkg::rsp_type predict_policer(input ktbp_pkg::req_type r);
      ktbp_pkg::rsp_type o;
      o = '0;
      o.allowed = 1;
      o.deny_reason = ktbp_pkg::DENY_NONE;
      if (r.kind == ktbp_pkg::KIND_REQUEST) begin
         if (p_enabled[0]) begin
            if (p_reqs != '1) p_reqs++;
            if (p_grate != 0 && !spend_token(p_gtok, p_glast, p_grate))
               o.deny_reason = ktbp_pkg::DENY_GLOBAL;
            else if (p_arate != 0 && r.address_present &&
                     !police_key(addr_lru, r.address_key, p_arate, p_alim))
               o.deny_reason = ktbp_pkg::DENY_ADDRESS;
            else if (p_crate != 0 && r.client_present &&
                     !police_key(cli_lru, r.client_key, p_crate, p_clim))
               o.deny_reason = ktbp_pkg::DENY_CLIENT;
            if (o.deny_reason != ktbp_pkg::DENY_NONE) begin
               o.allowed = 0;
               if (p_denied != '1) p_denied++;
            end
         end
      end else if (r.kind == ktbp_pkg::KIND_TICK) begin
         if (p_now != '1) p_now++;
      end else if (r.kind == ktbp_pkg::KIND_SWEEP) begin
         if (p_enabled[0]) begin
            o.address_swept = 7'(sweep_stale(addr_lru, p_arate));
            o.client_swept = 7'(sweep_stale(cli_lru, p_crate));
         end
      end
      o.address_count = 7'(addr_lru.size());
      o.client_count = 7'(cli_lru.size());
      o.request_total = p_reqs;
      o.denied_total = p_denied;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d on result %0d: %s got %0h expected %0h",
               cycle, checked, what, got, want);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 10000000) begin
         $display("timeout after %0d cycles", cycle);
         $display("keyed_token_bucket_policer_unit regression: fail");
         $finish;
      end
   end

   // Result checking.
   always @(posedge clock) begin
      ktbp_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", 64'd1, 64'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (got.allowed !== want.allowed)
               report_mismatch("allowed", got.allowed, want.allowed);
            if (got.deny_reason !== want.deny_reason)
               report_mismatch("deny_reason", got.deny_reason, want.deny_reason);
            if (got.address_count !== want.address_count)
               report_mismatch("address_count", got.address_count, want.address_count);
            if (got.client_count !== want.client_count)
               report_mismatch("client_count", got.client_count, want.client_count);
            if (got.request_total !== want.request_total)
               report_mismatch("request_total", got.request_total, want.request_total);
            if (got.denied_total !== want.denied_total)
               report_mismatch("denied_total", got.denied_total, want.denied_total);
            if (got.address_swept !== want.address_swept)
               report_mismatch("address_swept", got.address_swept, want.address_swept);
            if (got.client_swept !== want.client_swept)
               report_mismatch("client_swept", got.client_swept, want.client_swept);
            if (want.address_swept != 0 || want.client_swept != 0) sweeps_seen++;
            if (!want.allowed) denials_seen++;
            checked++;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here.
   initial begin
      int held;
      rsp_ch.ready = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_off && held < 400) begin
            rsp_ch.ready <= 0;
            held++;
         end else begin
            if (!hold_off) held = 0;
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= value;
      unique case (idx)
         ktbp_pkg::REG_ENABLED: p_enabled = value & 16'h1;
         ktbp_pkg::REG_GLOBAL: begin
            p_grate = value;
            p_gtok = capacity(p_grate);
            p_glast = p_now;
         end
         ktbp_pkg::REG_ADDRESS: p_arate = value;
         ktbp_pkg::REG_CLIENT: p_crate = value;
         ktbp_pkg::REG_BURST: begin
            p_burst = value & 16'h1f;
            p_gtok = capacity(p_grate);
            p_glast = p_now;
         end
         ktbp_pkg::REG_ADDR_LIMIT: p_alim = value & 16'h7f;
         ktbp_pkg::REG_CLI_LIMIT: p_clim = value & 16'h7f;
         ktbp_pkg::REG_STALE: p_stale = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // Lets the block drain completely before a register write.
   task automatic drain;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Offers one transaction at a falling edge and withdraws it at the falling
   // edge after acceptance.
   task automatic send_item(input ktbp_pkg::req_type r, input bit has_rsp,
                            input ktbp_pkg::rsp_type fixed);
      ktbp_pkg::rsp_type pred;
      while ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_ch.valid <= 0;
      end
      @(negedge clock);
      req_ch.valid <= 1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = predict_policer(r);
      expected_rsps.push_back(has_rsp ? fixed : pred);
      sent++;
      @(negedge clock);
      req_ch.valid <= 0;
   endtask

   function automatic ktbp_pkg::req_type make_req(input logic [1:0] kind,
                                                  input logic [63:0] ak, input bit ap,
                                                  input logic [63:0] ck, input bit cp);
      ktbp_pkg::req_type r;
      r.kind = kind;
      r.address_key = ak;
      r.address_present = ap;
      r.client_key = ck;
      r.client_present = cp;
      return r;
   endfunction

   function automatic ktbp_pkg::rsp_type plain_rsp(input bit ok, input logic [1:0] why,
                                                   input int ac, input int cc,
                                                   input int rq, input int dn);
      ktbp_pkg::rsp_type o;
      o = '0;
      o.allowed = ok;
      o.deny_reason = why;
      o.address_count = 7'(ac);
      o.client_count = 7'(cc);
      o.request_total = 32'(rq);
      o.denied_total = 32'(dn);
      return o;
   endfunction

   // Mostly keys from a small pool so that lookups hit; otherwise wide random.
   function automatic logic [63:0] pick_key(input int pool);
      if ($urandom_range(9) < 8) return 64'h5a5a_0000_0000_0000 | 64'($urandom_range(pool));
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(input int n, input int pool);
      ktbp_pkg::req_type r;
      int k;
      repeat (n) begin
         k = $urandom_range(99);
         r = make_req(k < 65 ? ktbp_pkg::KIND_REQUEST : (k < 90 ? ktbp_pkg::KIND_TICK :
                      (k < 98 ? ktbp_pkg::KIND_SWEEP : KindUnused)),
                      pick_key(pool), $urandom_range(9) != 0,
                      pick_key(pool), $urandom_range(9) != 0);
         // Occasionally jump time forward so that buckets go stale.
         if (r.kind == ktbp_pkg::KIND_TICK && $urandom_range(19) == 0)
            repeat ($urandom_range(30, 10)) send_item(r, 1'b0, '0);
         send_item(r, 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_type rows[$];
      ktbp_pkg::req_type r;
      logic [63:0] ones;
      ones = '1;
      reset = 1;
      csr_wr_en = 0;
      csr_index = ktbp_pkg::REG_ENABLED;
      csr_wr_data = 0;
      req_ch.valid = 0;
      req_ch.payload = '0;
      p_enabled = 0; p_grate = 0; p_arate = 0; p_crate = 0; p_burst = 1;
      p_alim = 64; p_clim = 64; p_stale = 300;
      p_now = 0; p_glast = 0; p_reqs = 0; p_denied = 0;
      p_gtok = capacity(p_grate);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: disabled limiter first, then tight buckets.
      rows.push_back('{make_req(ktbp_pkg::KIND_REQUEST, ones, 1'b1, ones, 1'b1), 1'b1,
                       plain_rsp(1'b1, ktbp_pkg::DENY_NONE, 0, 0, 0, 0)});
      rows.push_back('{make_req(ktbp_pkg::KIND_TICK, 64'd0, 1'b0, 64'd0, 1'b0), 1'b1,
                       plain_rsp(1'b1, ktbp_pkg::DENY_NONE, 0, 0, 0, 0)});
      rows.push_back('{make_req(ktbp_pkg::KIND_SWEEP, 64'd0, 1'b0, 64'd0, 1'b0), 1'b1,
                       plain_rsp(1'b1, ktbp_pkg::DENY_NONE, 0, 0, 0, 0)});
      rows.push_back('{make_req(KindUnused, ones, 1'b1, ones, 1'b1), 1'b1,
                       plain_rsp(1'b1, ktbp_pkg::DENY_NONE, 0, 0, 0, 0)});
      foreach (rows[i]) send_item(rows[i].item, rows[i].has_rsp, rows[i].rsp);
      drain();
      write_reg(ktbp_pkg::REG_ENABLED, 16'd1);
      write_reg(ktbp_pkg::REG_GLOBAL, 16'd2);
      write_reg(ktbp_pkg::REG_ADDRESS, 16'd1);
      write_reg(ktbp_pkg::REG_CLIENT, 16'd1);
      write_reg(ktbp_pkg::REG_BURST, 16'd1);
      write_reg(ktbp_pkg::REG_ADDR_LIMIT, 16'd2);
      write_reg(ktbp_pkg::REG_CLI_LIMIT, 16'd0);
      write_reg(ktbp_pkg::REG_STALE, 16'd0);
      rows.delete();
      // Global holds two tokens; second address request finds its bucket empty.
      rows.push_back('{make_req(ktbp_pkg::KIND_REQUEST, 64'd0, 1'b1, 64'd0, 1'b1), 1'b1,
                       plain_rsp(1'b1, ktbp_pkg::DENY_NONE, 1, 1, 1, 0)});
      rows.push_back('{make_req(ktbp_pkg::KIND_REQUEST, 64'd0, 1'b1, ones, 1'b1), 1'b1,
                       plain_rsp(1'b0, ktbp_pkg::DENY_ADDRESS, 1, 1, 2, 1)});
      rows.push_back('{make_req(ktbp_pkg::KIND_REQUEST, ones, 1'b1, ones, 1'b1), 1'b1,
                       plain_rsp(1'b0, ktbp_pkg::DENY_GLOBAL, 1, 1, 3, 2)});
      foreach (rows[i]) send_item(rows[i].item, rows[i].has_rsp, rows[i].rsp);
      // Eviction, client denial, ticks, sweeps, absent keys: predictor-checked.
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0: r = make_req(ktbp_pkg::KIND_TICK, 64'd0, 1'b0, 64'd0, 1'b0);
            1: r = make_req(ktbp_pkg::KIND_REQUEST, 64'(i), i[3], ones - 64'(i), !i[3]);
            2: r = make_req(ktbp_pkg::KIND_REQUEST, ones, 1'b1,
                            64'h8000_0000_0000_0001, 1'b1);
            default: r = make_req(ktbp_pkg::KIND_SWEEP, 64'd0, 1'b0, 64'd0, 1'b0);
         endcase
         send_item(r, 1'b0, '0);
      end
      drain();

      // Random phases across settings and idling patterns.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 56; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 56; end
            default: begin send_idle = 10; recv_stall = 10; end
         endcase
         write_reg(ktbp_pkg::REG_ENABLED, 16'(ph != 3));
         write_reg(ktbp_pkg::REG_GLOBAL,
                   ph == 7 ? 16'hffff : 16'($urandom_range(ph * 40)));
         write_reg(ktbp_pkg::REG_ADDRESS, ph == 5 ? 16'hffff : 16'($urandom_range(6)));
         write_reg(ktbp_pkg::REG_CLIENT, ph == 6 ? 16'hffff : 16'($urandom_range(6)));
         write_reg(ktbp_pkg::REG_BURST,
                   ph == 4 ? 16'd31 : (ph == 2 ? 16'd0 : 16'($urandom_range(16, 1))));
         write_reg(ktbp_pkg::REG_ADDR_LIMIT, ph == 1 ? 16'd127 : 16'($urandom_range(64)));
         write_reg(ktbp_pkg::REG_CLI_LIMIT, ph == 6 ? 16'd64 : 16'($urandom_range(70)));
         write_reg(ktbp_pkg::REG_STALE, ph == 7 ? 16'hffff : 16'($urandom_range(20)));
         if (ph == 2) begin
            hold_off = 1;
            random_phase(20, 12);
            hold_off = 0;
         end
         random_phase(120, ph == 6 ? 90 : 12);
         drain();
      end

      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("covered %0d transactions, %0d results checked, %0d denials, %0d sweeps",
               sent, checked, denials_seen, sweeps_seen);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("keyed_token_bucket_policer_unit regression: pass");
      else
         $display("keyed_token_bucket_policer_unit regression: fail");
      $finish;
   end

endmodule
